>>> rtl/sprite_attribute_emitter_macros.svh
// Assertion helpers, clocked on clk and held off while rst_n is low
`ifndef SPRITE_ATTRIBUTE_EMITTER_MACROS_SVH
`define SPRITE_ATTRIBUTE_EMITTER_MACROS_SVH

`define SAE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite attribute emitter check failed");

`define SAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite attribute emitter check failed");

`endif

>>> rtl/sae_pkg.sv
package sae_pkg;

  localparam int unsigned OBJECT_SLOTS_DEF = 128;

  localparam logic KIND_AFFINE = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  localparam logic [15:0] AFFINE_TAG = 16'hFFFF;
  localparam logic [31:0] LIST_END   = 32'h0000_0001;
  localparam logic [15:0] TILE_MASK  = 16'hF3FF;
  localparam logic [8:0]  X_HIDDEN   = 9'h180;
  localparam int unsigned AFFINE_FLAG_BIT = 8;

  localparam logic signed [16:0] X_MAX   = 17'sh00100;
  localparam logic signed [16:0] Y_MAX   = 17'sh000A0;
  localparam logic signed [16:0] POS_MIN = -17'sh00040;

  typedef struct packed {
    logic        new_frame;
    logic        first_of_list;
    logic [31:0] header;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0] oam_base;
    logic [15:0] tile_base;
  } rec_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  affine_group;
    logic [15:0] aff_pa;
    logic [15:0] aff_pb;
    logic [15:0] aff_pc;
    logic [15:0] aff_pd;
    logic [31:0] attr_low;
    logic [15:0] attr_tile;
  } res_t;

  typedef struct packed {
    logic take;
    logic load;
  } stage_ctl_t;

endpackage

>>> rtl/sae_rec_if.sv
interface sae_rec_if;
  logic        valid;
  logic        ready;
  logic        new_frame;
  logic        first_of_list;
  logic [31:0] header;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic [15:0] word_c;
  logic [15:0] word_d;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [31:0] oam_base;
  logic [15:0] tile_base;

  modport source (
    output valid, new_frame, first_of_list, header, word_a, word_b, word_c, word_d,
    output pos_x, pos_y, oam_base, tile_base,
    input  ready
  );

  modport sink (
    input  valid, new_frame, first_of_list, header, word_a, word_b, word_c, word_d,
    input  pos_x, pos_y, oam_base, tile_base,
    output ready
  );
endinterface

interface sae_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  affine_group;
  logic [15:0] aff_pa;
  logic [15:0] aff_pb;
  logic [15:0] aff_pc;
  logic [15:0] aff_pd;
  logic [31:0] attr_low;
  logic [15:0] attr_tile;

  modport source (
    output valid, kind, affine_group, aff_pa, aff_pb, aff_pc, aff_pd, attr_low, attr_tile,
    input  ready
  );

  modport sink (
    input  valid, kind, affine_group, aff_pa, aff_pb, aff_pc, aff_pd, attr_low, attr_tile,
    output ready
  );
endinterface

>>> rtl/sae_input_stage.sv
module sae_input_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  sae_rec_if.sink                in_rec,
  input  sae_pkg::stage_ctl_t    ctl,
  output logic                   rec_vld,
  output sae_pkg::rec_t          rec
);

  logic          vld_r;
  logic          vld_nxt;
  sae_pkg::rec_t rec_r;
  logic          accept;

  assign in_rec.ready = !vld_r || ctl.take;
  assign accept       = in_rec.valid && in_rec.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (ctl.take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_r.new_frame     <= in_rec.new_frame;
      rec_r.first_of_list <= in_rec.first_of_list;
      rec_r.header        <= in_rec.header;
      rec_r.word_a        <= in_rec.word_a;
      rec_r.word_b        <= in_rec.word_b;
      rec_r.word_c        <= in_rec.word_c;
      rec_r.word_d        <= in_rec.word_d;
      rec_r.pos_x         <= in_rec.pos_x;
      rec_r.pos_y         <= in_rec.pos_y;
      rec_r.oam_base      <= in_rec.oam_base;
      rec_r.tile_base     <= in_rec.tile_base;
    end
  end

  assign rec_vld = vld_r;
  assign rec     = rec_r;

endmodule

>>> rtl/sae_core.sv
`include "sprite_attribute_emitter_macros.svh"

module sae_core #(
  parameter int unsigned OBJECT_SLOTS = sae_pkg::OBJECT_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rec_vld,
  input  sae_pkg::rec_t          rec,
  input  logic                   out_free,
  output sae_pkg::stage_ctl_t    ctl,
  output sae_pkg::res_t          res
);

  localparam logic [7:0] SLOT_LIMIT = 8'(OBJECT_SLOTS);

  logic [6:0]  acnt_r, acnt_nxt;
  logic [6:0]  base_r, base_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  slot_r, slot_nxt;
  logic        done_r, done_nxt;

  logic [6:0]  acnt_eff;
  logic [6:0]  base_eff;
  logic [15:0] left_eff;
  logic [7:0]  slot_eff;
  logic        done_eff;
  logic        emit;

  logic signed [16:0] x_sum;
  logic signed [16:0] y_sum;
  logic               off_screen;
  logic [8:0]         x_bits;
  logic [31:0]        aff_part;
  logic [31:0]        attr_sum;

  always_comb begin
    acnt_eff = rec.new_frame ? 7'd0 : acnt_r;
    slot_eff = rec.new_frame ? 8'd0 : slot_r;
    base_eff = base_r;
    left_eff = left_r;
    done_eff = done_r;
    if (rec.first_of_list) begin
      base_eff = acnt_eff;
      done_eff = 1'b0;
      left_eff = (rec.header[31:16] == sae_pkg::AFFINE_TAG) ? rec.header[15:0] : 16'd0;
    end
  end

  always_comb begin
    x_sum = $signed({rec.word_b[15], rec.word_b}) + $signed({rec.pos_x[15], rec.pos_x});
    y_sum = $signed({rec.word_c[15], rec.word_c}) + $signed({rec.pos_y[15], rec.pos_y});
    off_screen = (x_sum > sae_pkg::X_MAX) || (x_sum < sae_pkg::POS_MIN) ||
                 (y_sum > sae_pkg::Y_MAX) || (y_sum < sae_pkg::POS_MIN);
    x_bits   = off_screen ? sae_pkg::X_HIDDEN : x_sum[8:0];
    aff_part = rec.header[sae_pkg::AFFINE_FLAG_BIT] ? {base_eff, 25'd0} : 32'd0;
    attr_sum = rec.header + aff_part + rec.oam_base;
  end

  always_comb begin
    acnt_nxt = acnt_eff;
    base_nxt = base_eff;
    left_nxt = left_eff;
    slot_nxt = slot_eff;
    done_nxt = done_eff;
    emit     = 1'b0;
    res      = '0;
    if (!done_eff) begin
      if (left_eff != 16'd0) begin
        emit             = 1'b1;
        res.kind         = sae_pkg::KIND_AFFINE;
        res.affine_group = acnt_eff;
        res.aff_pa       = rec.word_a;
        res.aff_pb       = rec.word_b;
        res.aff_pc       = rec.word_c;
        res.aff_pd       = rec.word_d;
        acnt_nxt         = acnt_eff + 7'd1;
        left_nxt         = left_eff - 16'd1;
      end else if (rec.header == sae_pkg::LIST_END || slot_eff >= SLOT_LIMIT) begin
        done_nxt = 1'b1;
      end else begin
        emit          = 1'b1;
        res.kind      = sae_pkg::KIND_OBJECT;
        res.attr_low  = attr_sum | {7'd0, x_bits, 16'd0} | {24'd0, y_sum[7:0]};
        res.attr_tile = (rec.word_a & sae_pkg::TILE_MASK) + rec.tile_base;
        slot_nxt      = slot_eff + 8'd1;
      end
    end
  end

  assign ctl.take = rec_vld && (!emit || out_free);
  assign ctl.load = ctl.take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acnt_r <= 7'd0;
      base_r <= 7'd0;
      left_r <= 16'd0;
      slot_r <= 8'd0;
      done_r <= 1'b1;
    end else if (ctl.take) begin
      acnt_r <= acnt_nxt;
      base_r <= base_nxt;
      left_r <= left_nxt;
      slot_r <= slot_nxt;
      done_r <= done_nxt;
    end
  end

  `SAE_ASSERT_NOW(a_load_on_take, ctl.load, ctl.take && out_free)
  `SAE_ASSERT_NOW(a_closed_list_silent, rec_vld && done_eff, !emit)
  `SAE_ASSERT_NEXT(a_group_advance, ctl.load && res.kind == sae_pkg::KIND_AFFINE,
                   acnt_r == $past(acnt_eff + 7'd1))
  `SAE_ASSERT_NOW(a_slot_bound, 1'b1, slot_r <= SLOT_LIMIT)

endmodule

>>> rtl/sae_output_stage.sv
module sae_output_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sae_pkg::stage_ctl_t    ctl,
  input  sae_pkg::res_t          res,
  output logic                   out_free,
  sae_res_if.source              out_res
);

  logic          vld_r;
  logic          vld_nxt;
  sae_pkg::res_t res_r;

  assign out_free = !vld_r || out_res.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (ctl.load) begin
      vld_nxt = 1'b1;
    end else if (out_res.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_r <= res;
    end
  end

  assign out_res.valid        = vld_r;
  assign out_res.kind         = res_r.kind;
  assign out_res.affine_group = res_r.affine_group;
  assign out_res.aff_pa       = res_r.aff_pa;
  assign out_res.aff_pb       = res_r.aff_pb;
  assign out_res.aff_pc       = res_r.aff_pc;
  assign out_res.aff_pd       = res_r.aff_pd;
  assign out_res.attr_low     = res_r.attr_low;
  assign out_res.attr_tile    = res_r.attr_tile;

endmodule

>>> rtl/sprite_attribute_emitter.sv
// Channel   Dir  Handshake      Transaction
// in_rec    in   valid/ready    one sprite-list record
// out_res   out  valid/ready    one affine group or one object attribute, or none
//
// One record per cycle sustained while out_res.ready holds.
// Record register feeds one pass of adds and compares into the result register.
// Synchronous active-low reset empties both registers and closes any open list.
// A stalled result holds the record register only when that record emits.
module sprite_attribute_emitter #(
  parameter int unsigned OBJECT_SLOTS = sae_pkg::OBJECT_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sae_rec_if.sink    in_rec,
  sae_res_if.source  out_res
);

  logic                rec_vld;
  sae_pkg::rec_t       rec;
  sae_pkg::stage_ctl_t ctl;
  sae_pkg::res_t       res;
  logic                out_free;

  sae_input_stage u_input (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rec  (in_rec),
    .ctl     (ctl),
    .rec_vld (rec_vld),
    .rec     (rec)
  );

  sae_core #(
    .OBJECT_SLOTS (OBJECT_SLOTS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec_vld  (rec_vld),
    .rec      (rec),
    .out_free (out_free),
    .ctl      (ctl),
    .res      (res)
  );

  sae_output_stage u_output (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .res      (res),
    .out_free (out_free),
    .out_res  (out_res)
  );

endmodule
